[src/pra_pkg.sv]
// Package for the page run allocator: payload structs, config struct, codes, FSM states.
// Used by every module under src except pra_page_mem; depends on nothing.
package pra_pkg;

  localparam int unsigned REGION_PAGES = 1024;
  localparam int unsigned BYTES_W      = 23;
  localparam int unsigned PAGE_NUM_W   = 20;
  localparam int unsigned CNT_OUT_W    = 11;
  localparam int unsigned PAGE_SHIFT   = 12;
  localparam int unsigned NPAGE_W      = BYTES_W + 1 - PAGE_SHIFT;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [BYTES_W-1:0]    THRESHOLD_RST = BYTES_W'(2048);
  localparam logic [PAGE_NUM_W-1:0] HEAP_BASE_RST = '0;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_HEAP_BASE = 1'b1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BLOCK    = 2'd2,
    ST_FREE_IGN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_CLAIM,
    S_FREE_CHK,
    S_FREE_OWN,
    S_WALK,
    S_TRIM,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic                  action;
    logic [BYTES_W-1:0]    request_bytes;
    logic [PAGE_NUM_W-1:0] free_page_number;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [PAGE_NUM_W-1:0] start_page_number;
    logic [CNT_OUT_W-1:0]  page_count;
    logic [CNT_OUT_W-1:0]  break_offset;
  } out_item_t;

  typedef struct packed {
    logic [BYTES_W-1:0]    block_threshold;
    logic [PAGE_NUM_W-1:0] heap_base_page;
  } cfg_t;

endpackage

[src/pra_page_mem.sv]
// Page table memory: one word per page, {used, owner}, one write and one read port.
// Read data registered. No package dependency.
module pra_page_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/pra_cfg_regs.sv]
// APB register file: block threshold and heap base page.
// Depends on pra_pkg.
module pra_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pra_pkg::APB_AW-1:0] paddr,
  input  logic [pra_pkg::APB_DW-1:0] pwdata,
  output logic [pra_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output pra_pkg::cfg_t              cfg_o
);
  import pra_pkg::*;

  logic [BYTES_W-1:0]    thr_q, thr_d;
  logic [PAGE_NUM_W-1:0] base_q, base_d;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    thr_d  = thr_q;
    base_d = base_q;
    if (wr_en) begin
      case (paddr[2])
        REG_THRESHOLD: thr_d  = pwdata[BYTES_W-1:0];
        REG_HEAP_BASE: base_d = pwdata[PAGE_NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      base_q <= HEAP_BASE_RST;
    end else begin
      thr_q  <= thr_d;
      base_q <= base_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = APB_DW'(thr_q);
      REG_HEAP_BASE: prdata = APB_DW'(base_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.block_threshold = thr_q;
  assign cfg_o.heap_base_page  = base_q;

endmodule

[src/pra_engine.sv]
// Allocation engine: sequencer and datapath around the page table memory.
// Scans gaps, claims runs, walks and trims on free. Depends on pra_pkg.
module pra_engine #(
  parameter int unsigned NumPages = pra_pkg::REGION_PAGES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pra_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_rdy_o,
  input  pra_pkg::in_item_t           in_item_i,
  output logic                        res_vld_o,
  input  logic                        res_rdy_i,
  output pra_pkg::out_item_t          res_item_o,
  output logic                        mem_re_o,
  output logic [$clog2(NumPages)-1:0] mem_raddr_o,
  output logic                        mem_we_o,
  output logic [$clog2(NumPages)-1:0] mem_waddr_o,
  output logic [$clog2(NumPages):0]   mem_wdata_o,
  input  logic [$clog2(NumPages):0]   mem_rdata_i
);
  import pra_pkg::*;

  localparam int unsigned IdxW = $clog2(NumPages);
  localparam int unsigned CntW = $clog2(NumPages + 1);
  localparam int unsigned CmpW = (CntW > NPAGE_W) ? CntW : NPAGE_W;
  localparam logic [CmpW-1:0] NumPagesC = CmpW'(NumPages);

  state_e state_q, state_d;

  logic [BYTES_W-1:0]    bytes_q, bytes_d;
  logic [NPAGE_W-1:0]    npages_q, npages_d;
  logic [PAGE_NUM_W-1:0] off_q, off_d;
  logic [CntW-1:0]       break_q, break_d;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic                  beat_vld_q, beat_vld_d;
  logic                  beat_inr_q, beat_inr_d;
  logic [IdxW-1:0]       beat_idx_q, beat_idx_d;
  logic                  in_gap_q, in_gap_d;
  logic [IdxW-1:0]       gap_start_q, gap_start_d;
  logic [IdxW-1:0]       pick_start_q, pick_start_d;
  logic [CntW-1:0]       pick_len_q, pick_len_d;
  logic                  exact_q, exact_d;
  logic [IdxW-1:0]       run_start_q, run_start_d;
  logic [NPAGE_W-1:0]    left_q, left_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  status_e               res_status_q, res_status_d;
  logic                  res_has_q, res_has_d;
  logic [CmpW-1:0]       res_cnt_q, res_cnt_d;

  logic                  in_acc;
  logic [BYTES_W:0]      bytes_round;
  logic                  used_w;
  logic [IdxW-1:0]       own_w;
  logic [CmpW-1:0]       npages_ext;
  logic [CntW-1:0]       gap_len, tail_len, ptr_dec;
  logic                  scan_more, close_gap, exact_hit, tail_exact;
  logic                  walk_take, trim_take, walk_more;
  logic                  fits_best, fits_grow, is_block, too_big, off_out;

  assign in_acc      = in_valid_i & in_rdy_o;
  assign bytes_round = {1'b0, in_item_i.request_bytes} + (BYTES_W + 1)'((1 << PAGE_SHIFT) - 1);
  assign used_w      = mem_rdata_i[IdxW];
  assign own_w       = mem_rdata_i[IdxW-1:0];
  assign npages_ext  = CmpW'(npages_q);
  assign gap_len     = CntW'(beat_idx_q) - CntW'(gap_start_q);
  assign tail_len    = break_q - CntW'(gap_start_q);
  assign ptr_dec     = ptr_q - CntW'(1);
  assign scan_more   = (ptr_q != break_q);
  assign walk_more   = (ptr_q < break_q);
  assign close_gap   = beat_vld_q & used_w & in_gap_q;
  assign exact_hit   = close_gap & (CmpW'(gap_len) == npages_ext);
  assign tail_exact  = (CmpW'(tail_len) == npages_ext);
  assign walk_take   = beat_vld_q & beat_inr_q & used_w & (own_w == run_start_q);
  assign trim_take   = beat_vld_q & beat_inr_q & ~used_w;
  assign fits_best   = exact_q | (CmpW'(pick_len_q) >= npages_ext);
  assign fits_grow   = npages_ext <= (NumPagesC - CmpW'(break_q));
  assign is_block    = bytes_q <= cfg_i.block_threshold;
  assign too_big     = npages_ext > NumPagesC;
  assign off_out     = off_q >= PAGE_NUM_W'(break_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_item_i.action == ACT_FREE) ? S_FREE_CHK : S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (is_block) begin
          state_d = S_RESULT;
        end else if (break_q == '0) begin
          state_d = too_big ? S_RESULT : S_CLAIM;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (exact_hit) begin
          state_d = S_DECIDE;
        end else if (!scan_more && !beat_vld_q) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: state_d = S_DECIDE;
      S_DECIDE:   state_d = (fits_best || fits_grow) ? S_CLAIM : S_RESULT;
      S_CLAIM: begin
        if (left_q == NPAGE_W'(1)) begin
          state_d = S_RESULT;
        end
      end
      S_FREE_CHK: state_d = off_out ? S_RESULT : S_FREE_OWN;
      S_FREE_OWN: state_d = used_w ? S_WALK : S_RESULT;
      S_WALK: begin
        if (beat_vld_q && !walk_take) begin
          state_d = S_TRIM;
        end
      end
      S_TRIM: begin
        if (beat_vld_q && !trim_take) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_rdy_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs: handshake and memory port control
  always_comb begin
    in_rdy_o    = 1'b0;
    res_vld_o   = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[IdxW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q[IdxW-1:0];
    mem_wdata_o = {1'b1, run_start_q};
    case (state_q)
      S_IDLE:   in_rdy_o  = 1'b1;
      S_RESULT: res_vld_o = 1'b1;
      S_SCAN:   mem_re_o  = scan_more;
      S_CLAIM:  mem_we_o  = 1'b1;
      S_FREE_CHK: begin
        mem_re_o    = ~off_out;
        mem_raddr_o = off_q[IdxW-1:0];
      end
      S_WALK: begin
        mem_re_o    = walk_more;
        mem_we_o    = walk_take;
        mem_waddr_o = beat_idx_q;
        mem_wdata_o = {1'b0, run_start_q};
      end
      S_TRIM: begin
        mem_re_o    = (ptr_q != '0);
        mem_raddr_o = ptr_dec[IdxW-1:0];
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    bytes_d      = bytes_q;
    npages_d     = npages_q;
    off_d        = off_q;
    break_d      = break_q;
    ptr_d        = ptr_q;
    beat_vld_d   = 1'b0;
    beat_inr_d   = beat_inr_q;
    beat_idx_d   = beat_idx_q;
    in_gap_d     = in_gap_q;
    gap_start_d  = gap_start_q;
    pick_start_d = pick_start_q;
    pick_len_d   = pick_len_q;
    exact_d      = exact_q;
    run_start_d  = run_start_q;
    left_d       = left_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_has_d    = res_has_q;
    res_cnt_d    = res_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          bytes_d  = in_item_i.request_bytes;
          npages_d = bytes_round[BYTES_W:PAGE_SHIFT];
          off_d    = in_item_i.free_page_number - cfg_i.heap_base_page;
        end
      end
      S_ALLOC: begin
        res_status_d = ST_NO_SPACE;
        res_has_d    = 1'b0;
        res_cnt_d    = '0;
        if (is_block) begin
          res_status_d = ST_BLOCK;
        end else if (break_q == '0) begin
          if (!too_big) begin
            run_start_d  = '0;
            ptr_d        = '0;
            left_d       = npages_q;
            break_d      = CntW'(npages_q);
            res_status_d = ST_DONE;
            res_has_d    = 1'b1;
            res_cnt_d    = npages_ext;
          end
        end else begin
          ptr_d        = '0;
          in_gap_d     = 1'b0;
          pick_start_d = '0;
          pick_len_d   = '0;
          exact_d      = 1'b0;
        end
      end
      S_SCAN: begin
        if (scan_more) begin
          beat_vld_d = 1'b1;
          beat_idx_d = ptr_q[IdxW-1:0];
          ptr_d      = ptr_q + CntW'(1);
        end
        if (beat_vld_q) begin
          if (!used_w && !in_gap_q) begin
            gap_start_d = beat_idx_q;
            in_gap_d    = 1'b1;
          end else if (close_gap) begin
            in_gap_d = 1'b0;
            if (exact_hit) begin
              pick_start_d = gap_start_q;
              exact_d      = 1'b1;
              beat_vld_d   = 1'b0;
            end else if (gap_len > pick_len_q) begin
              pick_start_d = gap_start_q;
              pick_len_d   = gap_len;
            end
          end
        end
      end
      S_SCAN_END: begin
        if (in_gap_q) begin
          if (tail_exact) begin
            pick_start_d = gap_start_q;
            exact_d      = 1'b1;
          end else if (tail_len > pick_len_q) begin
            pick_start_d = gap_start_q;
            pick_len_d   = tail_len;
          end
        end
      end
      S_DECIDE: begin
        res_status_d = ST_DONE;
        res_has_d    = 1'b1;
        res_cnt_d    = npages_ext;
        left_d       = npages_q;
        if (fits_best) begin
          run_start_d = pick_start_q;
          ptr_d       = CntW'(pick_start_q);
        end else if (fits_grow) begin
          run_start_d = break_q[IdxW-1:0];
          ptr_d       = break_q;
          break_d     = break_q + CntW'(npages_q);
        end else begin
          res_status_d = ST_NO_SPACE;
          res_has_d    = 1'b0;
          res_cnt_d    = '0;
        end
      end
      S_CLAIM: begin
        ptr_d  = ptr_q + CntW'(1);
        left_d = left_q - NPAGE_W'(1);
      end
      S_FREE_CHK: begin
        res_status_d = ST_FREE_IGN;
        res_has_d    = 1'b0;
        res_cnt_d    = '0;
      end
      S_FREE_OWN: begin
        run_start_d = own_w;
        ptr_d       = CntW'(own_w);
        cnt_d       = '0;
      end
      S_WALK: begin
        beat_vld_d = 1'b1;
        beat_idx_d = ptr_q[IdxW-1:0];
        beat_inr_d = walk_more;
        if (walk_more) begin
          ptr_d = ptr_q + CntW'(1);
        end
        if (walk_take) begin
          cnt_d = cnt_q + CntW'(1);
        end else if (beat_vld_q) begin
          beat_vld_d = 1'b0;
          ptr_d      = break_q;
        end
      end
      S_TRIM: begin
        beat_vld_d = 1'b1;
        beat_idx_d = ptr_dec[IdxW-1:0];
        beat_inr_d = (ptr_q != '0);
        if (ptr_q != '0) begin
          ptr_d = ptr_dec;
        end
        if (trim_take) begin
          break_d = CntW'(beat_idx_q);
        end else if (beat_vld_q) begin
          beat_vld_d   = 1'b0;
          res_status_d = ST_DONE;
          res_has_d    = 1'b1;
          res_cnt_d    = CmpW'(cnt_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      break_q    <= '0;
      beat_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      break_q    <= break_d;
      beat_vld_q <= beat_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q      <= bytes_d;
    npages_q     <= npages_d;
    off_q        <= off_d;
    ptr_q        <= ptr_d;
    beat_inr_q   <= beat_inr_d;
    beat_idx_q   <= beat_idx_d;
    in_gap_q     <= in_gap_d;
    gap_start_q  <= gap_start_d;
    pick_start_q <= pick_start_d;
    pick_len_q   <= pick_len_d;
    exact_q      <= exact_d;
    run_start_q  <= run_start_d;
    left_q       <= left_d;
    cnt_q        <= cnt_d;
    res_status_q <= res_status_d;
    res_has_q    <= res_has_d;
    res_cnt_q    <= res_cnt_d;
  end

  assign res_item_o.status            = res_status_q;
  assign res_item_o.start_page_number = res_has_q ?
      (cfg_i.heap_base_page + PAGE_NUM_W'(run_start_q)) : '0;
  assign res_item_o.page_count        = CNT_OUT_W'(res_cnt_q);
  assign res_item_o.break_offset      = CNT_OUT_W'(break_q);

endmodule

[src/page_run_allocator.sv]
// Page run allocator top level: config registers, engine, page table memory, output register.
// Depends on pra_pkg, pra_cfg_regs, pra_engine, pra_page_mem.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (pra_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_item_o (pra_pkg::out_item_t)
//   cfg      input      APB psel/penable/pready   paddr, pwdata, prdata
//
// One transaction at a time. Block-sized transactions, ignored frees and oversize requests on
// an empty region go straight to the result. An allocate on an empty region writes one entry
// per page. On a non-empty region it does one memory read per page below the break, then one
// memory write per claimed page; an exact-size gap ends the scan early. A free walks the run
// and then trims unused pages below the break, through the single memory port pair.
// The page table is not cleared: entries at and above the break are never read.
// out_stall_i only holds a finished result; a new transaction is taken as soon as the
// engine hands its result to the output register.
module page_run_allocator #(
  parameter int unsigned NumPages = pra_pkg::REGION_PAGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pra_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pra_pkg::out_item_t         out_item_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pra_pkg::APB_AW-1:0] paddr,
  input  logic [pra_pkg::APB_DW-1:0] pwdata,
  output logic [pra_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import pra_pkg::*;

  localparam int unsigned IdxW = $clog2(NumPages);

  cfg_t      cfg;
  logic      in_rdy;
  logic      res_vld, res_rdy;
  out_item_t res_item;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic            mem_re, mem_we;
  logic [IdxW-1:0] mem_raddr, mem_waddr;
  logic [IdxW:0]   mem_wdata, mem_rdata;

  pra_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pra_engine #(
    .NumPages (NumPages)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_rdy_o    (in_rdy),
    .in_item_i   (in_item_i),
    .res_vld_o   (res_vld),
    .res_rdy_i   (res_rdy),
    .res_item_o  (res_item),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  pra_page_mem #(
    .Depth (NumPages),
    .Width (IdxW + 1)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = ~in_rdy;
  assign res_rdy    = ~out_valid_q | ~out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (res_vld && res_rdy) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
